FILE: sv/eti_pkg.sv
// ----------------------------------------------------------------------------
// eti_pkg
// Shared types and helpers for the escape-time fractal iterator: the
// controller state encoding, the multiplier operand select, the command and
// status bundles between controller and datapath, and 32-bit saturation.
// ----------------------------------------------------------------------------
package eti_pkg;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ   = 6'b000010,
        S_EVAL = 6'b000100,
        S_M1   = 6'b001000,
        S_M2   = 6'b010000,
        S_UPD  = 6'b100000
    } t_state;

    // Operand sets for the two shared multipliers
    typedef enum logic [1:0] {
        MUL_SQ = 2'd0,  // x*x, y*y
        MUL_A  = 2'd1,  // quadratic: x*y; cubic: xx*x, x*yy
        MUL_B  = 2'd2   // cubic: xx*y, yy*y
    } t_mul;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture a new item
        t_mul mul_sel;  // multiplier operand set
        logic save_sq;  // keep the latest squares as xx, yy
        logic hold_a;   // park the first cubic product pair
        logic upd_z;    // write the new z
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic escape;   // |z|^2 above the mode's limit
    } t_stat;

    // Clamp a signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/eti_ctrl.sv
// ----------------------------------------------------------------------------
// eti_ctrl
// Sequencer for one item: orders the multiply, evaluate and update steps of
// each iteration, keeps the step count and raises the result strobe.
// ----------------------------------------------------------------------------
module eti_ctrl #(
    parameter int MAX_STEPS = 200
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_cubic,
    input  eti_pkg::t_stat                   i_stat,
    output eti_pkg::t_cmd                    o_cmd,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic [$clog2(MAX_STEPS+1)-1:0]   o_count
);
    import eti_pkg::*;

    localparam int CW = $clog2(MAX_STEPS + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_first, n_first;
    logic            r_valid, n_valid;
    t_cmd            cmd;

    // Next state, commands and count
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_valid     = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MUL_SQ;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_cnt    = '0;
                    n_first  = 1'b1;
                    n_state  = S_SQ;
                end
            end
            S_SQ: begin
                cmd.mul_sel = MUL_SQ;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                cmd.save_sq = 1'b1;
                n_first     = 1'b0;
                if (r_first) begin
                    // squares of the start point only feed the first step
                    n_state = S_M1;
                end else if (i_stat.escape) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CW'(MAX_STEPS - 1)) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_M1;
                    end
                end
            end
            S_M1: begin
                cmd.mul_sel = MUL_A;
                n_state     = i_cubic ? S_M2 : S_UPD;
            end
            S_M2: begin
                cmd.mul_sel = MUL_B;
                cmd.hold_a  = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                cmd.upd_z = 1'b1;
                n_state   = S_SQ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_count = r_cnt;

    // Strobe only comes up with the sequencer back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // Strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

    // Count never passes the step limit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_STEPS))
        else $error("step count out of range");

    // An accepted item makes the sequencer busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && (r_state == S_IDLE)) |=> (r_state == S_SQ))
        else $error("item accepted but sequencer did not start");

endmodule

FILE: sv/eti_dp.sv
// ----------------------------------------------------------------------------
// eti_dp
// Datapath: z and c registers, two shared 32x32 multipliers with registered
// floored products, the complex update with saturation and the escape test.
// ----------------------------------------------------------------------------
module eti_dp #(
    parameter int FRAC_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_cubic,
    input  eti_pkg::t_cmd        i_cmd,
    input  logic signed [31:0]   i_start_real,
    input  logic signed [31:0]   i_start_imag,
    input  logic signed [31:0]   i_const_real,
    input  logic signed [31:0]   i_const_imag,
    output eti_pkg::t_stat       o_stat,
    output logic signed [31:0]   o_final_real,
    output logic signed [31:0]   o_final_imag
);
    import eti_pkg::*;

    // Floored product width, and headroom for the update sums
    localparam int PW = 64 - FRAC_BITS;
    localparam int SW = PW + 3;
    localparam logic signed [63:0] LIM_QUAD = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [63:0] LIM_CUB  = (64'sd28 <<< FRAC_BITS) / 64'sd10;

    logic signed [31:0]   r_x, r_y, r_cr, r_ci;
    logic signed [31:0]   n_x, n_y;
    logic signed [PW-1:0] r_xx, r_yy, r_p0, r_p1, r_q0, r_q1;
    logic signed [31:0]   sxx, syy;
    logic signed [31:0]   a0, b0, a1, b1;
    logic signed [63:0]   prod0, prod1, sh0, sh1;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [PW:0]   mag;

    // Saturated squares as cubic operands
    assign sxx = sat32(64'(r_xx));
    assign syy = sat32(64'(r_yy));

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                a0 = r_x;  b0 = r_x;  a1 = r_y;  b1 = r_y;
            end
            MUL_A: begin
                if (i_cubic) begin
                    a0 = sxx;  b0 = r_x;  a1 = r_x;  b1 = syy;
                end else begin
                    a0 = r_x;  b0 = r_y;  a1 = r_x;  b1 = r_y;
                end
            end
            MUL_B: begin
                a0 = sxx;  b0 = r_y;  a1 = syy;  b1 = r_y;
            end
            default: begin
                a0 = r_x;  b0 = r_x;  a1 = r_y;  b1 = r_y;
            end
        endcase
    end

    // Multiply and floor to Q format
    assign prod0 = a0 * b0;
    assign prod1 = a1 * b1;
    assign sh0   = prod0 >>> FRAC_BITS;
    assign sh1   = prod1 >>> FRAC_BITS;

    // New z from the held products
    always_comb begin
        if (i_cubic) begin
            sum_x = SW'(r_q0) - ((SW'(r_q1) <<< 1) + SW'(r_q1)) + SW'(r_cr);
            sum_y = ((SW'(r_p0) <<< 1) + SW'(r_p0)) - SW'(r_p1) + SW'(r_ci);
        end else begin
            sum_x = SW'(r_xx) - SW'(r_yy) + SW'(r_cr);
            sum_y = (SW'(r_p0) <<< 1) + SW'(r_ci);
        end
        n_x = sat32(64'(sum_x));
        n_y = sat32(64'(sum_y));
    end

    // Escape test on the squares of the new z
    assign mag           = (PW+1)'(r_p0) + (PW+1)'(r_p1);
    assign o_stat.escape = 64'(mag) > (i_cubic ? LIM_CUB : LIM_QUAD);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_p0 <= sh0[PW-1:0];
        r_p1 <= sh1[PW-1:0];
        if (i_cmd.load) begin
            r_x  <= i_start_real;
            r_y  <= i_start_imag;
            r_cr <= i_const_real;
            r_ci <= i_const_imag;
        end else if (i_cmd.upd_z) begin
            r_x <= n_x;
            r_y <= n_y;
        end
        if (i_cmd.save_sq) begin
            r_xx <= r_p0;
            r_yy <= r_p1;
        end
        if (i_cmd.hold_a) begin
            r_q0 <= r_p0;
            r_q1 <= r_p1;
        end
    end

    assign o_final_real = r_x;
    assign o_final_imag = r_y;

endmodule

FILE: sv/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time iterator for one pixel: z = z^2 + c or z = z^3 + c in signed
// Q fixed point, counting steps until |z|^2 passes the limit.
// Each step squares z, evaluates, multiplies (twice in cubic mode) and updates
//   z; a run holds 1..MAX_STEPS steps from accept to strobe.
// Throughput: one item at a time; a new item is taken in the strobe cycle.
//   Each step is bound by the two shared multipliers (two or three passes).
// Reset clears the sequencer and cubic_mode; the receiver cannot stall.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator #(
    parameter int MAX_STEPS = 200,
    parameter int FRAC_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item command port
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_start_real,
    input  logic signed [31:0]   i_start_imag,
    input  logic signed [31:0]   i_const_real,
    input  logic signed [31:0]   i_const_imag,
    // result port
    output logic                 o_valid,
    output logic [7:0]           o_iteration_count,
    output logic signed [31:0]   o_final_real,
    output logic signed [31:0]   o_final_imag,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import eti_pkg::*;

    localparam int CW = $clog2(MAX_STEPS + 1);

    logic            r_cubic;
    logic            cfg_wr;
    t_cmd            cmd;
    t_stat           stat;
    logic [CW-1:0]   count;

    // Configuration register: cubic_mode at register 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cubic <= 1'b0;
        end else if (cfg_wr) begin
            r_cubic <= pwdata[0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_cubic};

    // Sequencer
    eti_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cubic (r_cubic),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_count (count)
    );

    // Arithmetic
    eti_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cubic      (r_cubic),
        .i_cmd        (cmd),
        .i_start_real (i_start_real),
        .i_start_imag (i_start_imag),
        .i_const_real (i_const_real),
        .i_const_imag (i_const_imag),
        .o_stat       (stat),
        .o_final_real (o_final_real),
        .o_final_imag (o_final_imag)
    );

    // Count field keeps the low eight bits
    assign o_iteration_count = 8'(count);

endmodule
